// ----- rtl/qaf_pkg.sv -----
// Shared types and constants for the quaternion attitude filter
`timescale 1ns / 1ps
package qaf_pkg;

  // Newton steps of the inverse square root
  localparam int RSQRT_ITERATIONS = 3;

  // Serial multiplier: signed A times signed B, one 4-bit digit of B per cycle
  localparam int QAF_AW   = 41;
  localparam int QAF_BW   = 36;
  localparam int QAF_PW   = QAF_AW + QAF_BW;
  localparam int QAF_DW   = 4;
  localparam int QAF_NDIG = QAF_BW / QAF_DW;
  localparam int QAF_CW   = $clog2(QAF_NDIG);

  // Accumulator width for sums of products
  localparam int QAF_ACW = 66;

  // Config port
  localparam int QAF_CIW = 2;
  localparam int QAF_CDW = 24;

  localparam logic [15:0] PROP_GAIN_RST     = 16'd11141;
  localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd262;
  localparam logic [23:0] HALF_PERIOD_RST   = 24'd8389;

  localparam logic signed [31:0] QAF_ONE = 32'sh4000_0000;

  typedef enum logic [QAF_CIW-1:0] {
    CFG_PROP_GAIN     = 2'd0,
    CFG_INTEGRAL_GAIN = 2'd1,
    CFG_HALF_PERIOD   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [23:0] accel_x;
    logic signed [23:0] accel_y;
    logic signed [23:0] accel_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } qaf_in_t;

  typedef struct packed {
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               updated;
  } qaf_out_t;

  typedef struct packed {
    logic                     start;
    logic signed [QAF_AW-1:0] a;
    logic signed [QAF_BW-1:0] b;
  } qaf_mul_req_t;

endpackage

// ----- rtl/qaf_mul.sv -----
// Digit-serial signed multiplier, one 4-bit digit of the multiplier per cycle
`timescale 1ns / 1ps
module qaf_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  qaf_pkg::qaf_mul_req_t               req,
  output logic                                done,
  output logic signed [qaf_pkg::QAF_PW-1:0]   prod
);
  import qaf_pkg::*;

  logic                     run;
  logic [QAF_CW-1:0]        cnt;
  logic signed [QAF_PW-1:0] mcand;
  logic [QAF_BW-1:0]        mplier;
  logic                     last;
  logic signed [QAF_DW:0]   digit;
  logic signed [QAF_PW-1:0] pp;

  // top digit carries the sign of B
  assign last  = (cnt == QAF_CW'(QAF_NDIG - 1));
  assign digit = {last ? mplier[QAF_DW-1] : 1'b0, mplier[QAF_DW-1:0]};
  assign pp    = mcand * digit;

  // digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= QAF_PW'(req.a);
      mplier <= req.b;
      prod   <= '0;
    end else if (run) begin
      prod   <= prod + pp;
      mcand  <= mcand <<< QAF_DW;
      mplier <= mplier >> QAF_DW;
    end
  end

endmodule

// ----- rtl/quaternion_attitude_filter_top.sv -----
// Quaternion attitude filter top level: sequencer, state and shared serial multiplier
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    in_data   (qaf_in_t)
//   out      out  out_valid/out_ready  out_data  (qaf_out_t)
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. Every product goes through one serial multiplier (issue, 9
// digits, write back); an item runs 71 products plus two normalize searches. An item
// with a zero acceleration component skips the filter step. Reset is synchronous;
// state is ready at once.
// A result waits in the output register; a stalled output holds the next result back.
`timescale 1ns / 1ps
module quaternion_attitude_filter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  qaf_pkg::qaf_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output qaf_pkg::qaf_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qaf_pkg::QAF_CIW-1:0]     cfg_index,
  input  logic [qaf_pkg::QAF_CDW-1:0]     cfg_data
);
  import qaf_pkg::*;

  localparam int ITW = $clog2(RSQRT_ITERATIONS + 1);

  localparam logic signed [QAF_ACW-1:0] MAX32  = QAF_ACW'(32'sh7FFF_FFFF);
  localparam logic signed [QAF_ACW-1:0] MIN32  = QAF_ACW'(32'sh8000_0000);
  localparam logic signed [QAF_ACW-1:0] NMAX32 = -MAX32;
  localparam logic signed [QAF_ACW-1:0] MAX40  = QAF_ACW'(40'sh7F_FFFF_FFFF);
  localparam logic signed [QAF_ACW-1:0] MIN40  = QAF_ACW'(40'sh80_0000_0000);
  localparam logic signed [QAF_ACW-1:0] THREE  = QAF_ACW'(34'sh0_C000_0000);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_SRCH  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // micro-op sequence, one product each (search is handled by S_SRCH)
  typedef enum logic [5:0] {
    OP_SA0, OP_SA1, OP_SA2, OP_SRCH,
    OP_IT_SQ, OP_IT_P, OP_IT_Y,
    OP_UX, OP_UY, OP_UZ,
    OP_VX0, OP_VX1, OP_VY0, OP_VY1, OP_VZ0, OP_VZ1, OP_VZ2, OP_VZ3,
    OP_EX0, OP_EX1, OP_EY0, OP_EY1, OP_EZ0, OP_EZ1,
    OP_IX, OP_IY, OP_IZ,
    OP_GX0, OP_GX1, OP_GY0, OP_GY1, OP_GZ0, OP_GZ1,
    OP_DW0, OP_DW1, OP_DW2, OP_NW,
    OP_DX0, OP_DX1, OP_DX2, OP_NX,
    OP_DY0, OP_DY1, OP_DY2, OP_NY,
    OP_DZ0, OP_DZ1, OP_DZ2, OP_NZ,
    OP_SN0, OP_SN1, OP_SN2, OP_SN3,
    OP_QW, OP_QX, OP_QY, OP_QZ
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [QAF_ACW-1:0] v);
    if (v > MAX32)      sat32 = 32'sh7FFF_FFFF;
    else if (v < MIN32) sat32 = 32'sh8000_0000;
    else                sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] satn(input logic signed [QAF_ACW-1:0] v);
    if (v > MAX32)       satn = 32'sh7FFF_FFFF;
    else if (v < NMAX32) satn = 32'sh8000_0001;
    else                 satn = v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [QAF_ACW-1:0] v);
    if (v > MAX40)      sat40 = 40'sh7F_FFFF_FFFF;
    else if (v < MIN40) sat40 = 40'sh80_0000_0000;
    else                sat40 = v[39:0];
  endfunction

  // linear seed of 1/sqrt(m), m in [0.25, 1) Q0.30, result Q2.30
  function automatic logic [31:0] rsqrt_seed(input logic [29:0] m);
    logic [31:0] m3;
    m3 = {2'b00, m} + {1'b0, m, 1'b0};
    if (!m[29]) rsqrt_seed = 32'hA000_0000 - {1'b0, m, 1'b0};
    else        rsqrt_seed = 32'h7000_0000 - (m3 >> 2);
  endfunction

  state_t state;
  op_t    pc;
  logic [ITW-1:0] it;
  logic   nq;
  logic   upd;

  logic [15:0] kp, ki;
  logic [23:0] hp;

  logic signed [31:0] qw, qx, qy, qz;
  logic signed [31:0] esx, esy, esz;

  logic signed [23:0] ax, ay, az;
  logic signed [31:0] rx, ry, rz;
  logic signed [32:0] ux, uy, uz;
  logic signed [31:0] vx, vy, vz, ex, ey, ez, gx, gy, gz;
  logic signed [39:0] dd;
  logic signed [31:0] nw, nx, ny, nz;

  logic signed [QAF_ACW-1:0] acc, sum;
  logic [63:0] nm;
  logic [5:0]  ee;
  logic [29:0] mreg;
  logic [31:0] rs, tt;
  logic [33:0] y2;

  logic signed [QAF_AW-1:0]  a_op;
  logic signed [QAF_BW-1:0]  b_op;
  qaf_mul_req_t              mreq;
  logic                      mul_done;
  logic signed [QAF_PW-1:0]  prod;
  logic signed [QAF_ACW-1:0] p0, p22, p24, p30, p31, pe;

  logic zero_acc;
  logic in_acc;
  logic out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);
  assign zero_acc  = (in_data.accel_x == '0) || (in_data.accel_y == '0) ||
                     (in_data.accel_z == '0);

  // rescaled views of the product
  assign p0  = QAF_ACW'(prod);
  assign p22 = QAF_ACW'(prod >>> 22);
  assign p24 = QAF_ACW'(prod >>> 24);
  assign p30 = QAF_ACW'(prod >>> 30);
  assign p31 = QAF_ACW'(prod >>> 31);
  assign pe  = QAF_ACW'(prod >>> ee);

  // operand select
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (pc)
      OP_SA0:   begin a_op = QAF_AW'(ax);   b_op = QAF_BW'(ax);  end
      OP_SA1:   begin a_op = QAF_AW'(ay);   b_op = QAF_BW'(ay);  end
      OP_SA2:   begin a_op = QAF_AW'(az);   b_op = QAF_BW'(az);  end
      OP_IT_SQ: begin a_op = QAF_AW'(rs);   b_op = QAF_BW'(rs);  end
      OP_IT_P:  begin a_op = QAF_AW'(mreg); b_op = QAF_BW'(y2);  end
      OP_IT_Y:  begin a_op = QAF_AW'(rs);   b_op = QAF_BW'(tt);  end
      OP_UX:    begin a_op = QAF_AW'(ax);   b_op = QAF_BW'(rs);  end
      OP_UY:    begin a_op = QAF_AW'(ay);   b_op = QAF_BW'(rs);  end
      OP_UZ:    begin a_op = QAF_AW'(az);   b_op = QAF_BW'(rs);  end
      OP_VX0:   begin a_op = QAF_AW'(qx);   b_op = QAF_BW'(qz);  end
      OP_VX1:   begin a_op = QAF_AW'(qw);   b_op = QAF_BW'(qy);  end
      OP_VY0:   begin a_op = QAF_AW'(qw);   b_op = QAF_BW'(qx);  end
      OP_VY1:   begin a_op = QAF_AW'(qy);   b_op = QAF_BW'(qz);  end
      OP_VZ0:   begin a_op = QAF_AW'(qw);   b_op = QAF_BW'(qw);  end
      OP_VZ1:   begin a_op = QAF_AW'(qx);   b_op = QAF_BW'(qx);  end
      OP_VZ2:   begin a_op = QAF_AW'(qy);   b_op = QAF_BW'(qy);  end
      OP_VZ3:   begin a_op = QAF_AW'(qz);   b_op = QAF_BW'(qz);  end
      OP_EX0:   begin a_op = QAF_AW'(uy);   b_op = QAF_BW'(vz);  end
      OP_EX1:   begin a_op = QAF_AW'(uz);   b_op = QAF_BW'(vy);  end
      OP_EY0:   begin a_op = QAF_AW'(uz);   b_op = QAF_BW'(vx);  end
      OP_EY1:   begin a_op = QAF_AW'(ux);   b_op = QAF_BW'(vz);  end
      OP_EZ0:   begin a_op = QAF_AW'(ux);   b_op = QAF_BW'(vy);  end
      OP_EZ1:   begin a_op = QAF_AW'(uy);   b_op = QAF_BW'(vx);  end
      OP_IX:    begin a_op = QAF_AW'(ex);   b_op = QAF_BW'(hp);  end
      OP_IY:    begin a_op = QAF_AW'(ey);   b_op = QAF_BW'(hp);  end
      OP_IZ:    begin a_op = QAF_AW'(ez);   b_op = QAF_BW'(hp);  end
      OP_GX0:   begin a_op = QAF_AW'(ex);   b_op = QAF_BW'(kp);  end
      OP_GX1:   begin a_op = QAF_AW'(esx);  b_op = QAF_BW'(ki);  end
      OP_GY0:   begin a_op = QAF_AW'(ey);   b_op = QAF_BW'(kp);  end
      OP_GY1:   begin a_op = QAF_AW'(esy);  b_op = QAF_BW'(ki);  end
      OP_GZ0:   begin a_op = QAF_AW'(ez);   b_op = QAF_BW'(kp);  end
      OP_GZ1:   begin a_op = QAF_AW'(esz);  b_op = QAF_BW'(ki);  end
      OP_DW0:   begin a_op = QAF_AW'(qx);   b_op = QAF_BW'(gx);  end
      OP_DW1:   begin a_op = QAF_AW'(qy);   b_op = QAF_BW'(gy);  end
      OP_DW2:   begin a_op = QAF_AW'(qz);   b_op = QAF_BW'(gz);  end
      OP_DX0:   begin a_op = QAF_AW'(qw);   b_op = QAF_BW'(gx);  end
      OP_DX1:   begin a_op = QAF_AW'(qy);   b_op = QAF_BW'(gz);  end
      OP_DX2:   begin a_op = QAF_AW'(qz);   b_op = QAF_BW'(gy);  end
      OP_DY0:   begin a_op = QAF_AW'(qw);   b_op = QAF_BW'(gy);  end
      OP_DY1:   begin a_op = QAF_AW'(qx);   b_op = QAF_BW'(gz);  end
      OP_DY2:   begin a_op = QAF_AW'(qz);   b_op = QAF_BW'(gx);  end
      OP_DZ0:   begin a_op = QAF_AW'(qw);   b_op = QAF_BW'(gz);  end
      OP_DZ1:   begin a_op = QAF_AW'(qx);   b_op = QAF_BW'(gy);  end
      OP_DZ2:   begin a_op = QAF_AW'(qy);   b_op = QAF_BW'(gx);  end
      OP_NW, OP_NX, OP_NY, OP_NZ:
                begin a_op = QAF_AW'(dd);   b_op = QAF_BW'(hp);  end
      OP_SN0:   begin a_op = QAF_AW'(nw);   b_op = QAF_BW'(nw);  end
      OP_SN1:   begin a_op = QAF_AW'(nx);   b_op = QAF_BW'(nx);  end
      OP_SN2:   begin a_op = QAF_AW'(ny);   b_op = QAF_BW'(ny);  end
      OP_SN3:   begin a_op = QAF_AW'(nz);   b_op = QAF_BW'(nz);  end
      OP_QW:    begin a_op = QAF_AW'(nw);   b_op = QAF_BW'(rs);  end
      OP_QX:    begin a_op = QAF_AW'(nx);   b_op = QAF_BW'(rs);  end
      OP_QY:    begin a_op = QAF_AW'(ny);   b_op = QAF_BW'(rs);  end
      OP_QZ:    begin a_op = QAF_AW'(nz);   b_op = QAF_BW'(rs);  end
      default:  begin a_op = '0;            b_op = '0;           end
    endcase
  end

  assign mreq.start = (state == S_ISSUE);
  assign mreq.a     = a_op;
  assign mreq.b     = b_op;

  qaf_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .prod (prod)
  );

  // accumulate step for each micro-op
  always_comb begin
    case (pc)
      OP_SA0, OP_SN0:                 sum = p0;
      OP_SA1, OP_SA2,
      OP_SN1, OP_SN2, OP_SN3:         sum = acc + p0;
      OP_VX0, OP_VY0, OP_VZ0,
      OP_EX0, OP_EY0, OP_EZ0:         sum = p30;
      OP_VX1, OP_VZ1, OP_VZ2,
      OP_EX1, OP_EY1, OP_EZ1:         sum = acc - p30;
      OP_VY1, OP_VZ3:                 sum = acc + p30;
      OP_IX:                          sum = QAF_ACW'(esx) + p24;
      OP_IY:                          sum = QAF_ACW'(esy) + p24;
      OP_IZ:                          sum = QAF_ACW'(esz) + p24;
      OP_GX0:                         sum = QAF_ACW'(rx) + p22;
      OP_GY0:                         sum = QAF_ACW'(ry) + p22;
      OP_GZ0:                         sum = QAF_ACW'(rz) + p22;
      OP_GX1, OP_GY1, OP_GZ1:         sum = acc + p22;
      OP_DW0:                         sum = -p24;
      OP_DX0, OP_DY0, OP_DZ0:         sum = p24;
      OP_DW1, OP_DW2, OP_DX2,
      OP_DY1, OP_DZ2:                 sum = acc - p24;
      OP_DX1, OP_DY2, OP_DZ1:         sum = acc + p24;
      OP_NW:                          sum = QAF_ACW'(qw) + p24;
      OP_NX:                          sum = QAF_ACW'(qx) + p24;
      OP_NY:                          sum = QAF_ACW'(qy) + p24;
      OP_NZ:                          sum = QAF_ACW'(qz) + p24;
      default:                        sum = acc;
    endcase
  end

  // control, config and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= OP_SA0;
      it        <= '0;
      nq        <= 1'b0;
      upd       <= 1'b0;
      out_valid <= 1'b0;
      kp        <= PROP_GAIN_RST;
      ki        <= INTEGRAL_GAIN_RST;
      hp        <= HALF_PERIOD_RST;
      qw        <= QAF_ONE;
      qx        <= '0;
      qy        <= '0;
      qz        <= '0;
      esx       <= '0;
      esy       <= '0;
      esz       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN:     kp <= cfg_data[15:0];
          CFG_INTEGRAL_GAIN: ki <= cfg_data[15:0];
          CFG_HALF_PERIOD:   hp <= cfg_data[23:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (zero_acc) begin
              upd   <= 1'b0;
              state <= S_FIN;
            end else begin
              upd   <= 1'b1;
              pc    <= OP_SA0;
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            state <= S_ISSUE;
            pc    <= op_t'(pc + 1'b1);
            case (pc)
              OP_SA2: begin
                nq    <= 1'b0;
                state <= S_SRCH;
              end
              OP_IT_Y: begin
                if (it == ITW'(RSQRT_ITERATIONS - 1)) begin
                  it <= '0;
                  pc <= nq ? OP_QW : OP_UX;
                end else begin
                  it <= it + 1'b1;
                  pc <= OP_IT_SQ;
                end
              end
              OP_IX: esx <= sat32(sum);
              OP_IY: esy <= sat32(sum);
              OP_IZ: esz <= sat32(sum);
              OP_SN3: begin
                if (sum == '0) begin
                  // degenerate norm falls back to identity
                  qw    <= QAF_ONE;
                  qx    <= '0;
                  qy    <= '0;
                  qz    <= '0;
                  pc    <= OP_SA0;
                  state <= S_FIN;
                end else begin
                  nq    <= 1'b1;
                  state <= S_SRCH;
                end
              end
              OP_QW: qw <= sat32(pe);
              OP_QX: qx <= sat32(pe);
              OP_QY: qy <= sat32(pe);
              OP_QZ: begin
                qz    <= sat32(pe);
                pc    <= OP_SA0;
                state <= S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          if (!(|nm[63:30]) && (|nm[63:28])) begin
            it    <= '0;
            pc    <= OP_IT_SQ;
            state <= S_ISSUE;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax <= in_data.accel_x;
      ay <= in_data.accel_y;
      az <= in_data.accel_z;
      rx <= in_data.rate_x;
      ry <= in_data.rate_y;
      rz <= in_data.rate_z;
    end

    if ((state == S_WAIT) && mul_done) begin
      acc <= sum;
      case (pc)
        OP_SA2, OP_SN3: begin
          nm <= sum[63:0];
          ee <= 6'd15;
        end
        OP_IT_SQ: y2 <= p30[33:0];
        OP_IT_P:  tt <= (p30 >= THREE) ? 32'd0 : 32'(THREE - p30);
        OP_IT_Y:  rs <= (p31 > THREE) ? THREE[31:0] : p31[31:0];
        OP_UX:    ux <= pe[32:0];
        OP_UY:    uy <= pe[32:0];
        OP_UZ:    uz <= pe[32:0];
        OP_VX1:   vx <= sat32(sum <<< 1);
        OP_VY1:   vy <= sat32(sum <<< 1);
        OP_VZ3:   vz <= sat32(sum);
        OP_EX1:   ex <= sat32(sum);
        OP_EY1:   ey <= sat32(sum);
        OP_EZ1:   ez <= sat32(sum);
        OP_GX1:   gx <= sat32(sum);
        OP_GY1:   gy <= sat32(sum);
        OP_GZ1:   gz <= sat32(sum);
        OP_DW2, OP_DX2, OP_DY2, OP_DZ2: dd <= sat40(sum);
        OP_NW:    nw <= satn(sum);
        OP_NX:    nx <= satn(sum);
        OP_NY:    ny <= satn(sum);
        OP_NZ:    nz <= satn(sum);
        default: ;
      endcase
    end

    // bring the radicand into [2^28, 2^30) two bits a cycle
    if (state == S_SRCH) begin
      if (|nm[63:30]) begin
        nm <= nm >> 2;
        ee <= ee + 1'b1;
      end else if (!(|nm[63:28])) begin
        nm <= nm << 2;
        ee <= ee - 1'b1;
      end else begin
        mreg <= nm[29:0];
        rs   <= rsqrt_seed(nm[29:0]);
      end
    end

    if (out_load) begin
      out_data.att_w   <= qw;
      out_data.att_x   <= qx;
      out_data.att_y   <= qy;
      out_data.att_z   <= qz;
      out_data.updated <= upd;
    end
  end

endmodule

// ----- rtl/qaf_checker.sv -----
// Port-level assertions for the quaternion attitude filter, bound to the top level
`timescale 1ns / 1ps
module qaf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input qaf_pkg::qaf_out_t out_data
);
  import qaf_pkg::*;

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the item was taken");

  // a waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // one item in flight: the input side closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind quaternion_attitude_filter_top qaf_checker u_qaf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/quaternion_attitude_filter_top_tb.sv -----
// Self-checking testbench for the quaternion attitude filter top level
`timescale 1ns / 1ps
module quaternion_attitude_filter_top_tb;
  import qaf_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  qaf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  qaf_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [QAF_CIW-1:0] cfg_index = '0;
  logic [QAF_CDW-1:0] cfg_data = '0;

  quaternion_attitude_filter_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor copy of configuration and filter state
  longint kp_gain, ki_gain, hp_step;
  longint qw, qx, qy, qz, isum_x, isum_y, isum_z;
  qaf_out_t attitude_q[$];
  int err_count = 0;
  int n_steps = 0, n_skips = 0, n_results = 0;
  longint cycle_count = 0;
  bit no_stall = 1'b0;

  function automatic longint asr(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint s32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint fmul30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // Newton inverse square root: 1/sqrt(s) = y * 2^-30 * 2^-e
  task automatic rsqrt(input longint unsigned s, output longint unsigned y, output int e);
    longint unsigned t, m, y2, p, tt;
    int len;
    len = 0;
    t = s;
    while (t != 0) begin
      len++;
      t = t >> 1;
    end
    e = (len + 1) / 2;
    m = (2 * e >= 30) ? (s >> (2 * e - 30)) : (s << (30 - 2 * e));
    if (m < (64'd1 << 29)) y = (64'd5 << 29) - 2 * m;
    else y = (64'd7 << 28) - ((3 * m) >> 2);
    for (int i = 0; i < RSQRT_ITERATIONS; i++) begin
      y2 = (y * y) >> 30;
      p = (m * y2) >> 30;
      tt = (p >= (64'd3 << 30)) ? 0 : (64'd3 << 30) - p;
      y = (y * tt) >> 31;
      if (y > (64'd3 << 30)) y = 64'd3 << 30;
    end
  endtask

  // One filter step on the predictor state
  task automatic predict_attitude(input qaf_in_t it);
    longint ax, ay, az, rx, ry, rz, vx, vy, vz, ex, ey, ez, gx, gy, gz;
    longint dw, dx, dy, dz, nw, nx, ny, nz, l39;
    longint unsigned s, r;
    int e;
    qaf_out_t res;
    ax = it.accel_x; ay = it.accel_y; az = it.accel_z;
    rx = it.rate_x; ry = it.rate_y; rz = it.rate_z;
    l39 = 64'sd1 << 39;
    if (ax != 0 && ay != 0 && az != 0) begin
      s = ax * ax + ay * ay + az * az;
      rsqrt(s, r, e);
      ax = asr(ax * longint'(r), e);
      ay = asr(ay * longint'(r), e);
      az = asr(az * longint'(r), e);
      vx = s32(2 * (fmul30(qx, qz) - fmul30(qw, qy)));
      vy = s32(2 * (fmul30(qw, qx) + fmul30(qy, qz)));
      vz = s32(fmul30(qw, qw) - fmul30(qx, qx) - fmul30(qy, qy) + fmul30(qz, qz));
      ex = s32(fmul30(ay, vz) - fmul30(az, vy));
      ey = s32(fmul30(az, vx) - fmul30(ax, vz));
      ez = s32(fmul30(ax, vy) - fmul30(ay, vx));
      isum_x = s32(isum_x + asr(hp_step * ex, 24));
      isum_y = s32(isum_y + asr(hp_step * ey, 24));
      isum_z = s32(isum_z + asr(hp_step * ez, 24));
      gx = s32(rx + asr(kp_gain * ex, 22) + asr(ki_gain * isum_x, 22));
      gy = s32(ry + asr(kp_gain * ey, 22) + asr(ki_gain * isum_y, 22));
      gz = s32(rz + asr(kp_gain * ez, 22) + asr(ki_gain * isum_z, 22));
      dw = -asr(qx * gx, 24) - asr(qy * gy, 24) - asr(qz * gz, 24);
      dx = asr(qw * gx, 24) + asr(qy * gz, 24) - asr(qz * gy, 24);
      dy = asr(qw * gy, 24) - asr(qx * gz, 24) + asr(qz * gx, 24);
      dz = asr(qw * gz, 24) + asr(qx * gy, 24) - asr(qy * gx, 24);
      nw = clip(qw + asr(clip(dw, -l39, l39 - 1) * hp_step, 24), -2147483647, 2147483647);
      nx = clip(qx + asr(clip(dx, -l39, l39 - 1) * hp_step, 24), -2147483647, 2147483647);
      ny = clip(qy + asr(clip(dy, -l39, l39 - 1) * hp_step, 24), -2147483647, 2147483647);
      nz = clip(qz + asr(clip(dz, -l39, l39 - 1) * hp_step, 24), -2147483647, 2147483647);
      s = nw * nw + nx * nx + ny * ny + nz * nz;
      if (s == 0) begin
        qw = QAF_ONE; qx = 0; qy = 0; qz = 0;
      end else begin
        rsqrt(s, r, e);
        qw = s32(asr(nw * longint'(r), e));
        qx = s32(asr(nx * longint'(r), e));
        qy = s32(asr(ny * longint'(r), e));
        qz = s32(asr(nz * longint'(r), e));
      end
      res.updated = 1'b1;
      n_steps++;
    end else begin
      res.updated = 1'b0;
      n_skips++;
    end
    res.att_w = qw[31:0]; res.att_x = qx[31:0]; res.att_y = qy[31:0]; res.att_z = qz[31:0];
    attitude_q.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // Send one sample after a random gap; valid stays high when the gap is zero
  task automatic send_sample(input qaf_in_t it);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_attitude(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PROP_GAIN: kp_gain = longint'(val[15:0]);
      CFG_INTEGRAL_GAIN: ki_gain = longint'(val[15:0]);
      CFG_HALF_PERIOD: hp_step = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki, input logic [23:0] hp);
    wait_drained();
    write_reg(CFG_PROP_GAIN, 24'(kp));
    write_reg(CFG_INTEGRAL_GAIN, 24'(ki));
    write_reg(CFG_HALF_PERIOD, hp);
    cfg_valid <= 1'b0;
  endtask

  function automatic qaf_in_t mk_sample(longint ax, longint ay, longint az,
                                        longint rx, longint ry, longint rz);
    qaf_in_t it;
    it.accel_x = ax[23:0]; it.accel_y = ay[23:0]; it.accel_z = az[23:0];
    it.rate_x = rx[31:0]; it.rate_y = ry[31:0]; it.rate_z = rz[31:0];
    return it;
  endfunction

  // Plausible IMU sample: gravity mostly on z, modest rates, sometimes full range
  function automatic qaf_in_t rand_sample();
    qaf_in_t it;
    it.accel_x = 24'($urandom);
    it.accel_y = 24'($urandom);
    it.accel_z = 24'($urandom);
    it.rate_x = $urandom;
    it.rate_y = $urandom;
    it.rate_z = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      it.accel_x = 24'($signed($urandom_range(0, 4000)) - 2000);
      it.accel_y = 24'($signed($urandom_range(0, 4000)) - 2000);
      it.accel_z = 24'($signed($urandom_range(0, 8000)) + 4000);
      it.rate_x = 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      it.rate_y = 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      it.rate_z = 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    end
    if ($urandom_range(0, 19) == 0) it.accel_x = 0;
    if ($urandom_range(0, 29) == 0) it.accel_z = 0;
    return it;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (attitude_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        qaf_out_t want;
        want = attitude_q.pop_front();
        if (out_data.att_w !== want.att_w) report_mismatch("att_w", out_data.att_w, want.att_w);
        if (out_data.att_x !== want.att_x) report_mismatch("att_x", out_data.att_x, want.att_x);
        if (out_data.att_y !== want.att_y) report_mismatch("att_y", out_data.att_y, want.att_y);
        if (out_data.att_z !== want.att_z) report_mismatch("att_z", out_data.att_z, want.att_z);
        if (out_data.updated !== want.updated)
          report_mismatch("updated", out_data.updated, want.updated);
      end
    end
  end

  // Receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (no_stall) begin
      out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      stall_left = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) stall_left = 0;
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed_edges();
    send_sample(mk_sample(0, 100, 100, 0, 0, 0));
    send_sample(mk_sample(100, 0, 100, 0, 0, 0));
    send_sample(mk_sample(100, 100, 0, 0, 0, 0));
    send_sample(mk_sample(1, 1, 1, 0, 0, 0));
    send_sample(mk_sample(-1, -1, -1, 0, 0, 0));
    send_sample(mk_sample(8388607, 8388607, 8388607, 2147483647, 2147483647, 2147483647));
    send_sample(mk_sample(-8388608, -8388608, -8388608,
                          -2147483648, -2147483648, -2147483648));
    send_sample(mk_sample(-8388608, 8388607, 1, 2147483647, -2147483648, 0));
    send_sample(mk_sample(3, -5, 1000, 1 << 24, -(1 << 24), 1 << 20));
    send_sample(mk_sample(0, 0, 0, 5, 5, 5));
  endtask

  task automatic test_gain_extremes();
    set_gains(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    for (int i = 0; i < 8; i++) send_sample(rand_sample());
    send_sample(mk_sample(8388607, -8388608, 8388607, 2147483647, -2147483648, 2147483647));
    set_gains(16'd0, 16'd0, 24'd0);
    for (int i = 0; i < 5; i++) send_sample(rand_sample());
  endtask

  task automatic test_random_run(input int n_items);
    for (int i = 0; i < n_items; i++) send_sample(rand_sample());
  endtask

  task automatic test_back_to_back();
    wait_drained();
    no_stall = 1'b1;
    for (int i = 0; i < 30; i++) send_sample(rand_sample());
    wait_drained();
    no_stall = 1'b0;
  endtask

  initial begin
    kp_gain = PROP_GAIN_RST; ki_gain = INTEGRAL_GAIN_RST; hp_step = HALF_PERIOD_RST;
    qw = QAF_ONE; qx = 0; qy = 0; qz = 0;
    isum_x = 0; isum_y = 0; isum_z = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_gain_extremes();
    set_gains(16'd11141, 16'd262, 24'd8389);
    test_random_run(500);
    set_gains(16'($urandom), 16'($urandom), 24'($urandom));
    test_random_run(400);
    test_back_to_back();
    set_gains(16'd40000, 16'd5000, 24'd2000000);
    test_random_run(420);
    wait_drained();
    $display("covered %0d filter steps and %0d skipped samples, %0d results checked",
             n_steps, n_skips, n_results);
    $display("gain settings included zero, full scale, defaults and random values");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/qaf_pkg.sv
rtl/qaf_mul.sv
rtl/quaternion_attitude_filter_top.sv
rtl/qaf_checker.sv
verif/quaternion_attitude_filter_top_tb.sv
